// ===== rtl/bitmap_run_allocator_assert.svh =====
// Assertion macros shared by the checker of the bitmap run allocator.
`ifndef BITMAP_RUN_ALLOCATOR_ASSERT_SVH
`define BITMAP_RUN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BRA_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap_run_allocator check failed");

// Next-cycle implication, disabled during reset.
`define BRA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap_run_allocator check failed");

`endif

// ===== rtl/bra_pkg.sv =====
// Shared types and constants of the bitmap run allocator.
package bra_pkg;

   localparam int WORD_BITS         = 32;
   localparam int DEFAULT_MAP_WORDS = 32;
   localparam logic [5:0]  ACTIVE_RESET = 6'd32;
   localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;

   // Command codes.
   typedef enum logic [3:0] {
      OP_CLEAR       = 4'd0,
      OP_FILL        = 4'd1,
      OP_SEARCH_FWD  = 4'd2,
      OP_SEARCH_REV  = 4'd3,
      OP_SET_BIT     = 4'd4,
      OP_CLEAR_BIT   = 4'd5,
      OP_SET_RUN     = 4'd6,
      OP_CLEAR_RUN   = 4'd7,
      OP_TEST        = 4'd8,
      OP_COUNT_ONES  = 4'd9,
      OP_COUNT_ZEROS = 4'd10,
      OP_XOR_WORD    = 4'd11
   } op_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_RUN,
      ST_RESP
   } state_type;

   // Controls handed to the word unit.
   typedef struct packed {
      op_type      op;
      logic [9:0]  pos;
      logic [10:0] len;
      logic [31:0] xor_val;
      logic [5:0]  word;
      logic [10:0] carry;
   } unit_ctrl_type;

   // Results of the word unit for one word.
   typedef struct packed {
      logic        hit;
      logic [4:0]  hit_idx;
      logic [10:0] carry;
      logic [31:0] new_word;
      logic [5:0]  ones;
   } unit_out_type;

endpackage

// ===== rtl/bitmap_run_allocator.sv =====
// Bitmap run allocator: one word unit steps through the bitmap memory one word a cycle.
// After reset the block clears every word of its memory before it takes the first
// command. A command then reads the bitmap words it visits one after another, and the
// word unit acts on each word once it is read. Clear, fill and the counts
// visit all active words. A forward search visits the words from the start word up to
// the hit or the last active word. A reverse search visits the words from the top active
// word down to the hit or word 0. Runs visit the words they cover. Bit commands, test and
// xor visit one word. Commands rejected by their bounds, zero-length runs, tests out of
// range and unused codes answer without visiting any word. The rate is set by the single
// read port of the bitmap memory feeding the word unit. The result word is held until
// taken, and no new command is accepted meanwhile.
module bitmap_run_allocator #(
   parameter int MAP_WORDS = bra_pkg::DEFAULT_MAP_WORDS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_op,
   input  logic [9:0]  req_bit_position,
   input  logic [10:0] req_run_length,
   input  logic [4:0]  req_word_index,
   input  logic [31:0] req_word_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [10:0] rsp_result_value,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);
   import bra_pkg::*;

   localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

   state_type    state_ff, state_in;
   logic [5:0]   active_ff, active_in;
   op_type       op_ff, op_in;
   logic [9:0]   pos_ff, pos_in;
   logic [10:0]  len_ff, len_in;
   logic [31:0]  xor_ff, xor_in;
   logic [5:0]   iss_ff, iss_in;
   logic [5:0]   left_ff, left_in;
   logic         rev_ff, rev_in;
   logic         dv_ff, dv_in;
   logic [5:0]   dw_ff, dw_in;
   logic [10:0]  carry_ff, carry_in;
   logic [10:0]  acc_ff, acc_in;
   logic         status_ff, status_in;
   logic [10:0]  value_ff, value_in;
   logic [AW-1:0] init_ff, init_in;
   logic [31:0]  rdata_ff;

   logic [31:0]  mem [MAP_WORDS];
   logic         mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]  mem_wdata;

   logic         accept;
   logic [5:0]   words;
   logic [11:0]  size;
   logic [11:0]  end_sum;
   logic [11:0]  last_pos;
   logic [5:0]   pos_word;
   logic         start_run;
   logic         start_fail;
   logic         start_rev;
   logic [5:0]   start_first;
   logic [5:0]   start_count;
   logic [10:0]  start_len;
   logic         done;
   logic [11:0]  base;
   unit_ctrl_type ctrl;
   unit_out_type  ures;
   op_type       req_op_e;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_status       = status_ff;
   assign rsp_result_value = value_ff;
   assign req_op_e  = op_type'(req_op);

   // Live word count, clamped to the memory depth.
   always_comb begin
      words = (active_ff == 6'd0) ? 6'd1 : active_ff;
      if (32'(words) > MAP_WORDS) begin
         words = 6'(MAP_WORDS);
      end
      size     = {1'b0, words, 5'b0};
      end_sum  = {2'b0, req_bit_position} + {1'b0, req_run_length};
      last_pos = end_sum - 12'd1;
      pos_word = {1'b0, req_bit_position[9:5]};
   end

   // Decode a command into a word range or an immediate answer.
   always_comb begin
      start_run   = 1'b0;
      start_fail  = 1'b0;
      start_rev   = 1'b0;
      start_first = '0;
      start_count = words;
      start_len   = req_run_length;
      unique case (req_op_e)
         OP_CLEAR, OP_FILL, OP_COUNT_ONES, OP_COUNT_ZEROS: begin
            start_run = 1'b1;
         end
         OP_SEARCH_FWD: begin
            if ((req_run_length != 11'd0) && ({1'b0, req_run_length} < size)
                && ({2'b0, req_bit_position} < size)) begin
               start_run   = 1'b1;
               start_first = pos_word;
               start_count = words - pos_word;
            end else begin
               start_fail = 1'b1;
            end
         end
         OP_SEARCH_REV: begin
            if ((req_run_length != 11'd0) && ({1'b0, req_run_length} < size)) begin
               start_run   = 1'b1;
               start_rev   = 1'b1;
               start_first = words - 6'd1;
            end else begin
               start_fail = 1'b1;
            end
         end
         OP_SET_BIT, OP_CLEAR_BIT: begin
            start_len = 11'd1;
            if ({2'b0, req_bit_position} < size) begin
               start_run   = 1'b1;
               start_first = pos_word;
               start_count = 6'd1;
            end else begin
               start_fail = 1'b1;
            end
         end
         OP_SET_RUN, OP_CLEAR_RUN: begin
            if (end_sum > size) begin
               start_fail = 1'b1;
            end else if (req_run_length != 11'd0) begin
               start_run   = 1'b1;
               start_first = pos_word;
               start_count = last_pos[10:5] - pos_word + 6'd1;
            end
         end
         OP_TEST: begin
            if ({2'b0, req_bit_position} < size) begin
               start_run   = 1'b1;
               start_first = pos_word;
               start_count = 6'd1;
            end
         end
         OP_XOR_WORD: begin
            if ({1'b0, req_word_index} < words) begin
               start_run   = 1'b1;
               start_first = {1'b0, req_word_index};
               start_count = 6'd1;
            end else begin
               start_fail = 1'b1;
            end
         end
         default: begin
            start_fail = 1'b1;
         end
      endcase
   end

   // Word unit on the word read in the previous cycle.
   always_comb begin
      ctrl.op      = op_ff;
      ctrl.pos     = pos_ff;
      ctrl.len     = len_ff;
      ctrl.xor_val = xor_ff;
      ctrl.word    = dw_ff;
      ctrl.carry   = carry_ff;
   end

   bra_word_unit u_word (
      .ctrl (ctrl),
      .data (rdata_ff),
      .res  (ures)
   );

   assign base = {1'b0, dw_ff, 5'b0};

   // Scan ends on a search hit or after the last word read.
   always_comb begin
      done = 1'b0;
      if (dv_ff) begin
         if ((op_ff == OP_SEARCH_FWD || op_ff == OP_SEARCH_REV) && ures.hit) begin
            done = 1'b1;
         end else if (left_ff == 6'd0) begin
            done = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: if (init_ff == LAST_ADDR) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) state_in = start_run ? ST_RUN : ST_RESP;
         end
         ST_RUN:  if (done) state_in = ST_RESP;
         ST_RESP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      active_in = csr_wr_en ? csr_wr_data : active_ff;
      op_in     = op_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      xor_in    = xor_ff;
      iss_in    = iss_ff;
      left_in   = left_ff;
      rev_in    = rev_ff;
      dv_in     = 1'b0;
      dw_in     = dw_ff;
      carry_in  = carry_ff;
      acc_in    = acc_ff;
      status_in = status_ff;
      value_in  = value_ff;
      init_in   = init_ff;
      mem_we    = 1'b0;
      mem_waddr = AW'(dw_ff);
      mem_wdata = ures.new_word;
      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = init_ff;
            mem_wdata = '0;
            init_in   = init_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_op_e;
               pos_in    = req_bit_position;
               len_in    = start_len;
               xor_in    = req_word_value;
               iss_in    = start_first;
               left_in   = start_count;
               rev_in    = start_rev;
               carry_in  = '0;
               acc_in    = '0;
               status_in = start_fail;
               value_in  = '0;
            end
         end
         ST_RUN: begin
            // Issue the next read.
            if (left_ff != 6'd0) begin
               dv_in   = 1'b1;
               dw_in   = iss_ff;
               iss_in  = rev_ff ? (iss_ff - 6'd1) : (iss_ff + 6'd1);
               left_in = left_ff - 6'd1;
            end
            // Act on the word read last cycle.
            if (dv_ff) begin
               case (op_ff)
                  OP_SEARCH_FWD: begin
                     carry_in = ures.carry;
                     if (ures.hit) begin
                        status_in = 1'b0;
                        value_in  = 11'(base + {7'b0, ures.hit_idx} + 12'd1
                                        - {1'b0, len_ff});
                     end else if (left_ff == 6'd0) begin
                        status_in = 1'b1;
                     end
                  end
                  OP_SEARCH_REV: begin
                     carry_in = ures.carry;
                     if (ures.hit) begin
                        status_in = 1'b0;
                        value_in  = 11'(base + 12'd31 - {7'b0, ures.hit_idx});
                     end else if (left_ff == 6'd0) begin
                        status_in = 1'b1;
                     end
                  end
                  OP_COUNT_ONES: begin
                     acc_in   = acc_ff + {5'b0, ures.ones};
                     value_in = acc_in;
                  end
                  OP_COUNT_ZEROS: begin
                     acc_in   = acc_ff + 11'(7'd32 - {1'b0, ures.ones});
                     value_in = acc_in;
                  end
                  OP_TEST: begin
                     value_in = {10'b0, rdata_ff[5'd31 - pos_ff[4:0]]};
                  end
                  default: begin
                     mem_we = 1'b1;
                  end
               endcase
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         active_ff <= ACTIVE_RESET;
         init_ff   <= '0;
         dv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         init_ff   <= init_in;
         dv_ff     <= dv_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      len_ff    <= len_in;
      xor_ff    <= xor_in;
      iss_ff    <= iss_in;
      left_ff   <= left_in;
      rev_ff    <= rev_in;
      dw_ff     <= dw_in;
      carry_ff  <= carry_in;
      acc_ff    <= acc_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

   // Bitmap memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[AW'(iss_ff)];
   end

endmodule

// ===== rtl/bra_word_unit.sv =====
// Word unit: run search, run mask, update and population count for one bitmap word.
module bra_word_unit (
   input  bra_pkg::unit_ctrl_type ctrl,
   input  logic [31:0]            data,
   output bra_pkg::unit_out_type  res
);
   import bra_pkg::*;

   logic [31:0] scan_bits;
   logic [31:0] mask;
   logic [11:0] base;
   logic [11:0] pos_x;
   logic [11:0] len_x;
   logic [11:0] end_x;
   logic [11:0] bit_pos;
   logic        seen;
   logic [4:0]  last_one;
   logic [11:0] run;
   logic [5:0]  ones;

   always_comb begin
      base      = {1'b0, ctrl.word, 5'b0};
      pos_x     = {2'b0, ctrl.pos};
      len_x     = {1'b0, ctrl.len};
      end_x     = pos_x + len_x;
      scan_bits = '0;
      mask      = '0;
      seen      = 1'b0;
      last_one  = '0;
      run       = '0;
      ones      = '0;
      bit_pos   = '0;
      res       = '0;

      // Put the bits in scan order; a forward scan treats bits before the start as taken.
      for (int j = 0; j < WORD_BITS; j++) begin
         if (ctrl.op == OP_SEARCH_REV) begin
            scan_bits[j] = data[j];
         end else begin
            scan_bits[j] = data[31-j] | ((base + 12'(j)) < pos_x);
         end
      end

      // Length of the zero run ending at each scan step; the first that reaches len hits.
      for (int j = 0; j < WORD_BITS; j++) begin
         if (scan_bits[j]) begin
            seen     = 1'b1;
            last_one = 5'(j);
            run      = '0;
         end else if (seen) begin
            run = 12'(j) - {7'b0, last_one};
         end else begin
            run = {1'b0, ctrl.carry} + 12'(j) + 12'd1;
         end
         if (!res.hit && (run >= len_x)) begin
            res.hit     = 1'b1;
            res.hit_idx = 5'(j);
         end
      end
      res.carry = run[10:0];

      // Bits of this word that fall inside the run.
      for (int j = 0; j < WORD_BITS; j++) begin
         bit_pos = base + 12'(31 - j);
         mask[j] = (bit_pos >= pos_x) && (bit_pos < end_x);
      end

      // Population count.
      for (int j = 0; j < WORD_BITS; j++) begin
         ones = ones + 6'(data[j]);
      end
      res.ones = ones;

      // Updated word.
      case (ctrl.op)
         OP_CLEAR:                           res.new_word = '0;
         OP_FILL:                            res.new_word = ALL_ONES;
         OP_SET_BIT, OP_SET_RUN:             res.new_word = data | mask;
         OP_CLEAR_BIT, OP_CLEAR_RUN:         res.new_word = data & ~mask;
         OP_XOR_WORD:                        res.new_word = data ^ ctrl.xor_val;
         default:                            res.new_word = data;
      endcase
   end

endmodule

// ===== rtl/bra_checker.sv =====
// Port checker of the bitmap run allocator and its bind to the top level.
`include "bitmap_run_allocator_assert.svh"

module bra_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [10:0] rsp_result_value
);

   // A waiting result word holds still.
   `BRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_result_value))

   // A failed command carries a zero value.
   `BRA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && rsp_status, rsp_result_value == 11'd0)

   // No command is taken while a result is pending.
   `BRA_ASSERT_NOW(a_one_at_a_time, clock, reset, rsp_valid, !req_ready)

   // An accepted command closes the input side in the next cycle.
   `BRA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_result_value (rsp_result_value)
);
